[rtl/swtm_pkg.sv]
// ----------------------------------------------------------------------------
// swtm_pkg
// Shared widths, constants and types of the moving trimmed-mean filter.
// ----------------------------------------------------------------------------
`default_nettype none

package swtm_pkg;

  // field widths fixed by the stream format
  localparam int SAMPLE_W = 24;
  localparam int MEAN_W   = 32;
  localparam int CNT_W    = 4;
  localparam int TRIM_W   = 3;
  localparam int FRAC_W   = 8;

  localparam logic [TRIM_W-1:0] TRIM_RESET = 3'd3;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OLD,
    ST_DROP,
    ST_INS,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } swtm_state_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } swtm_div_stat_t;

endpackage

`default_nettype wire

[rtl/swtm_div.sv]
// ----------------------------------------------------------------------------
// swtm_div
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swtm_div #(
  parameter int DW = 36,
  parameter int VW = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DW-1:0]         dividend,
  input  wire logic [VW-1:0]         divisor,
  output swtm_pkg::swtm_div_stat_t   stat,
  output logic      [DW-1:0]         quotient
);
  import swtm_pkg::*;

  localparam int DWP   = DW + (DW % 2);
  localparam int STEPS = DWP / 2;
  localparam int CNTW  = $clog2(STEPS + 1);

  logic [DWP-1:0]  work_r, work_nxt;
  logic [VW-1:0]   rem_r, rem_nxt;
  logic [VW-1:0]   dvs_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r, done_r;

  // two restoring steps on the remainder
  always_comb begin
    logic [VW:0]    t;
    logic [VW-1:0]  r;
    logic [DWP-1:0] w;
    r = rem_r;
    w = work_r;
    for (int k = 0; k < 2; k++) begin
      t = {r, w[DWP-1]};
      w = {w[DWP-2:0], 1'b0};
      if (t >= {1'b0, dvs_r}) begin
        t    = t - {1'b0, dvs_r};
        w[0] = 1'b1;
      end
      r = t[VW-1:0];
    end
    work_nxt = w;
    rem_nxt  = r;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      work_r <= DWP'(dividend);
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      work_r <= work_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = work_r[DW-1:0];

endmodule

`default_nettype wire

[rtl/sliding_window_trimmed_mean_core.sv]
// ----------------------------------------------------------------------------
// sliding_window_trimmed_mean_core
// Moving trimmed mean over the last WINDOW load-cell samples, Q8 result.
// ----------------------------------------------------------------------------
//
//  channel  direction  fields (low bit up)                     beat
//  in_      slave      tdata: sample; tuser: restart           one sample
//  out_     master     tdata: mean_q8, samples_used, fill      one mean
//  cfg_     slave      data: trim_count                        one write
//
//  Each sample runs through a drop sweep (once the window is full) and an
//  insert sweep over the sorted memory, one read per cycle, then a summing
//  sweep and a two-bit-per-cycle divider.
//  in_tready is high only while the sequencer is idle; a finished mean waits
//  in the output register, and the sequencer holds its result until taken.
//  rst_n is synchronous; the sample stores need no clearing after reset.
//
`default_nettype none

module sliding_window_trimmed_mean_core #(
  parameter int WINDOW = 15
) (
  input  wire logic                                              clk,
  input  wire logic                                              rst_n,
  // sample
  input  wire logic                                              in_tvalid,
  output logic                                                   in_tready,
  input  wire logic [swtm_pkg::SAMPLE_W-1:0]                     in_tdata,
  // restart
  input  wire logic [0:0]                                        in_tuser,
  output logic                                                   out_tvalid,
  input  wire logic                                              out_tready,
  // mean_q8 [31:0], samples_used [35:32], window_fill [39:36]
  output logic [swtm_pkg::MEAN_W+2*swtm_pkg::CNT_W-1:0]          out_tdata,
  input  wire logic                                              cfg_valid,
  output logic                                                   cfg_ready,
  // trim_count
  input  wire logic [swtm_pkg::TRIM_W-1:0]                       cfg_data
);
  import swtm_pkg::*;

  localparam int AW   = $clog2(WINDOW);
  localparam int CW   = $clog2(WINDOW + 1);
  localparam int CMPW = ((CW > TRIM_W + 1) ? CW : TRIM_W + 1) + 1;
  localparam int SW   = SAMPLE_W + CW;
  localparam int DW   = SW + FRAC_W;
  localparam int OW   = MEAN_W + 2 * CNT_W;

  swtm_state_t state_r, state_nxt;

  logic signed [SAMPLE_W-1:0] ring_mem [WINDOW];
  logic signed [SAMPLE_W-1:0] sort_mem [WINDOW];
  logic signed [SAMPLE_W-1:0] ring_rd_r, sort_rd_r;

  logic signed [SAMPLE_W-1:0] v_r, v_nxt;
  logic signed [SAMPLE_W-1:0] old_r, old_nxt;
  logic        [AW-1:0]       wp_r, wp_nxt;
  logic        [CW-1:0]       fill_r, fill_nxt;
  logic        [CW-1:0]       ptr_r, ptr_nxt;
  logic        [CW-1:0]       hi_r, hi_nxt;
  logic        [CW-1:0]       used_r, used_nxt;
  logic                       found_r, found_nxt;
  logic                       dv_r, dv_nxt;
  logic signed [SW-1:0]       acc_r, acc_nxt;
  logic        [TRIM_W-1:0]   trim_r;

  logic                       out_valid_r;
  logic        [OW-1:0]       out_data_r;
  logic                       out_load;

  logic                       ring_we;
  logic        [AW-1:0]       ring_a;
  logic                       sort_we;
  logic        [AW-1:0]       sort_wa, sort_ra;
  logic signed [SAMPLE_W-1:0] sort_wd;

  logic        [CW-1:0]       fill_eff;
  logic        [AW-1:0]       wp_eff;
  logic        [CW-1:0]       ptr_inc, ptr_m1, ptr_m2;
  logic                       plain;
  logic        [CMPW-1:0]     lo_w, hi_w;

  logic                       div_start;
  swtm_div_stat_t             div_stat;
  logic        [SW-1:0]       mag;
  logic        [DW-1:0]       dividend, quot, q_s;

  // restart empties the window ahead of this sample
  assign fill_eff = in_tuser[0] ? '0 : fill_r;
  assign wp_eff   = in_tuser[0] ? '0 : wp_r;
  assign ring_a   = wp_eff;

  assign ptr_inc = ptr_r + 1'b1;
  assign ptr_m1  = ptr_r - 1'b1;
  assign ptr_m2  = ptr_r - CW'(2);

  // mean range over the sorted copy
  assign plain = CMPW'(fill_r) < CMPW'({trim_r, 1'b1});
  assign lo_w  = plain ? '0 : CMPW'(trim_r);
  assign hi_w  = plain ? CMPW'(fill_r) : CMPW'(fill_r) - CMPW'(trim_r);

  // sequencer: next state and memory control
  always_comb begin
    state_nxt = state_r;
    v_nxt     = v_r;
    old_nxt   = old_r;
    wp_nxt    = wp_r;
    fill_nxt  = fill_r;
    ptr_nxt   = ptr_r;
    hi_nxt    = hi_r;
    used_nxt  = used_r;
    found_nxt = found_r;
    dv_nxt    = dv_r;
    acc_nxt   = acc_r;
    ring_we   = 1'b0;
    sort_we   = 1'b0;
    sort_wa   = '0;
    sort_wd   = v_r;
    sort_ra   = '0;
    div_start = 1'b0;
    out_load  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          ring_we = 1'b1;
          v_nxt   = in_tdata;
          wp_nxt  = (wp_eff == AW'(WINDOW - 1)) ? '0 : wp_eff + 1'b1;
          dv_nxt  = 1'b0;
          if (fill_eff < CW'(WINDOW)) begin
            fill_nxt  = fill_eff + 1'b1;
            ptr_nxt   = fill_eff;
            state_nxt = ST_INS;
          end else begin
            fill_nxt  = fill_eff;
            state_nxt = ST_OLD;
          end
        end
      end

      // leaving sample is in the ring read register
      ST_OLD: begin
        old_nxt   = ring_rd_r;
        sort_ra   = '0;
        ptr_nxt   = '0;
        found_nxt = 1'b0;
        state_nxt = ST_DROP;
      end

      // remove one copy of the leaving sample, shift the rest down
      ST_DROP: begin
        sort_ra = (ptr_r == CW'(WINDOW - 1)) ? '0 : ptr_inc[AW-1:0];
        if (!found_r) begin
          if (sort_rd_r == old_r) begin
            found_nxt = 1'b1;
          end
        end else begin
          sort_we = 1'b1;
          sort_wa = ptr_m1[AW-1:0];
          sort_wd = sort_rd_r;
        end
        ptr_nxt = ptr_inc;
        if (ptr_r == CW'(WINDOW - 1)) begin
          ptr_nxt   = CW'(WINDOW - 1);
          dv_nxt    = 1'b0;
          state_nxt = ST_INS;
        end
      end

      // insert from the top, moving larger entries up
      ST_INS: begin
        if (ptr_r == '0) begin
          sort_we   = 1'b1;
          sort_wa   = '0;
          state_nxt = ST_SUM;
        end else if (!dv_r) begin
          sort_ra = ptr_m1[AW-1:0];
          dv_nxt  = 1'b1;
        end else if (sort_rd_r > v_r) begin
          sort_we = 1'b1;
          sort_wa = ptr_r[AW-1:0];
          sort_wd = sort_rd_r;
          ptr_nxt = ptr_m1;
          sort_ra = (ptr_r == CW'(1)) ? '0 : ptr_m2[AW-1:0];
        end else begin
          sort_we   = 1'b1;
          sort_wa   = ptr_r[AW-1:0];
          state_nxt = ST_SUM;
        end
        if (state_nxt == ST_SUM) begin
          ptr_nxt  = CW'(lo_w);
          hi_nxt   = CW'(hi_w);
          used_nxt = CW'(hi_w - lo_w);
          acc_nxt  = '0;
          dv_nxt   = 1'b0;
        end
      end

      // accumulate sorted entries lo .. hi-1
      ST_SUM: begin
        if (dv_r) begin
          acc_nxt = acc_r + {{(SW - SAMPLE_W){sort_rd_r[SAMPLE_W-1]}}, sort_rd_r};
        end
        if (ptr_r != hi_r) begin
          sort_ra = ptr_r[AW-1:0];
          ptr_nxt = ptr_inc;
          dv_nxt  = 1'b1;
        end else begin
          dv_nxt = 1'b0;
          if (!dv_r) begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_OUT;
        end
      end

      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wp_r    <= '0;
      fill_r  <= '0;
      ptr_r   <= '0;
      hi_r    <= '0;
      used_r  <= '0;
      found_r <= 1'b0;
      dv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      fill_r  <= fill_nxt;
      ptr_r   <= ptr_nxt;
      hi_r    <= hi_nxt;
      used_r  <= used_nxt;
      found_r <= found_nxt;
      dv_r    <= dv_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    old_r <= old_nxt;
    acc_r <= acc_nxt;
  end

  // trim register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_r <= TRIM_RESET;
    end else if (cfg_valid) begin
      trim_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  // arrival ring, read-first
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_a] <= in_tdata;
    end
    ring_rd_r <= ring_mem[ring_a];
  end

  // sorted copy
  always_ff @(posedge clk) begin
    if (sort_we) begin
      sort_mem[sort_wa] <= sort_wd;
    end
    sort_rd_r <= sort_mem[sort_ra];
  end

  // magnitude divide, sign restored after
  assign mag      = acc_r[SW-1] ? SW'(-acc_r) : SW'(acc_r);
  assign dividend = {mag, FRAC_W'(0)};

  swtm_div #(
    .DW (DW),
    .VW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (used_r),
    .stat     (div_stat),
    .quotient (quot)
  );

  assign q_s = acc_r[SW-1] ? -quot : quot;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {CNT_W'(fill_r), CNT_W'(used_r), q_s[MEAN_W-1:0]};
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

[rtl/swtm_checker.sv]
// ----------------------------------------------------------------------------
// swtm_checker
// Port-level checks of the moving trimmed-mean filter, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module swtm_checker #(
  parameter int WINDOW = 15
) (
  input wire logic                                      clk,
  input wire logic                                      rst_n,
  input wire logic                                      in_tvalid,
  input wire logic                                      in_tready,
  input wire logic                                      out_tvalid,
  input wire logic                                      out_tready,
  input wire logic [swtm_pkg::MEAN_W+2*swtm_pkg::CNT_W-1:0] out_tdata
);
  import swtm_pkg::*;

  // a waiting mean beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out beat dropped while stalled");

  // a waiting mean beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out payload changed while stalled");

  // one sample at a time: busy right after a sample beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("sample taken while previous one in work");

  // samples used lie between one and the window fill
  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (WINDOW > 15) ||
      ((out_tdata[MEAN_W+CNT_W-1:MEAN_W] != '0) &&
       (out_tdata[MEAN_W+CNT_W-1:MEAN_W] <= out_tdata[MEAN_W+2*CNT_W-1:MEAN_W+CNT_W])))
    else $error("samples_used out of range");

endmodule

bind sliding_window_trimmed_mean_core swtm_checker #(
  .WINDOW (WINDOW)
) u_swtm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

[sim/trimmed_mean_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trimmed_mean_checker
// Watches the sample, mean and trim-write channels of the trimmed-mean core.
// It keeps its own copy of the arrival ring, the ranked window and trim
// count, works out the expected mean beat for every accepted sample, and
// compares each accepted mean beat field by field with the oldest one.
// ----------------------------------------------------------------------------

module trimmed_mean_checker #(
  parameter int WINDOW = 15
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_tvalid,
  input  logic                                           in_tready,
  input  logic [swtm_pkg::SAMPLE_W-1:0]                  in_tdata,
  input  logic [0:0]                                     in_tuser,
  input  logic                                           out_tvalid,
  input  logic                                           out_tready,
  input  logic [swtm_pkg::MEAN_W+2*swtm_pkg::CNT_W-1:0]  out_tdata,
  input  logic                                           cfg_valid,
  input  logic                                           cfg_ready,
  input  logic [swtm_pkg::TRIM_W-1:0]                    cfg_data,
  output int                                             mismatches,
  output int                                             means_pending
);
  import swtm_pkg::*;

  // one mean beat as it appears on out_tdata, low field last
  typedef struct packed {
    logic [CNT_W-1:0]  fill;
    logic [CNT_W-1:0]  used;
    logic [MEAN_W-1:0] mean_q8;
  } mean_beat_t;

  // shadow of the filter state
  int         hist_ring [WINDOW];
  int         ranked [WINDOW];
  int         ring_pos;
  int         held;
  int         trim;
  mean_beat_t expected_means [$];

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch in %s: got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // insert v into the first n ranked entries, ascending
  function automatic void rank_insert(input int n, input int v);
    int i;
    i = n;
    while (i > 0 && ranked[i-1] > v) begin
      ranked[i] = ranked[i-1];
      i--;
    end
    ranked[i] = v;
  endfunction

  // add one sample to the window and work out the mean beat it causes
  function automatic mean_beat_t advance_window(input int v, input logic restart);
    mean_beat_t r;
    int         p;
    int         old;
    int         lo;
    int         hi;
    int         i;
    longint     sum;
    if (restart) begin
      ring_pos = 0;
      held = 0;
    end
    if (held < WINDOW) begin
      hist_ring[held] = v;
      rank_insert(held, v);
      held++;
      ring_pos = (ring_pos + 1) % WINDOW;
    end else begin
      p = ring_pos % WINDOW;
      old = hist_ring[p];
      hist_ring[p] = v;
      ring_pos = (p + 1) % WINDOW;
      // drop the leaving sample, or the top entry if it is somehow absent
      i = 0;
      while (i < WINDOW && ranked[i] != old) i++;
      if (i == WINDOW) i = WINDOW - 1;
      while (i + 1 < WINDOW) begin
        ranked[i] = ranked[i+1];
        i++;
      end
      rank_insert(WINDOW - 1, v);
    end
    // plain mean while the window is too short to trim
    sum = 0;
    if (held < 2 * trim + 1) begin
      lo = 0;
      hi = held;
      for (i = lo; i < hi; i++) sum += hist_ring[i];
    end else begin
      lo = trim;
      hi = held - trim;
      for (i = lo; i < hi; i++) sum += ranked[i];
    end
    r.mean_q8 = MEAN_W'((sum * 256) / longint'(hi - lo));
    r.used = CNT_W'(hi - lo);
    r.fill = CNT_W'(held);
    return r;
  endfunction

  // beat tracking, mean beats first since they come from earlier samples
  always @(posedge clk) begin
    mean_beat_t got;
    mean_beat_t want;
    if (!rst_n) begin
      ring_pos = 0;
      held = 0;
      trim = TRIM_RESET;
      expected_means.delete();
      means_pending = 0;
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) trim = cfg_data;
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_means.size() == 0) begin
          report("mean beat with no sample waiting", $signed(got.mean_q8), 0);
        end else begin
          want = expected_means.pop_front();
          if (got.mean_q8 !== want.mean_q8)
            report("mean_q8", $signed(got.mean_q8), $signed(want.mean_q8));
          if (got.used !== want.used) report("samples_used", got.used, want.used);
          if (got.fill !== want.fill) report("window_fill", got.fill, want.fill);
        end
      end
      if (in_tvalid && in_tready)
        expected_means.push_back(advance_window($signed(in_tdata), in_tuser[0]));
      means_pending = expected_means.size();
    end
  end

endmodule

[sim/tb_sliding_window_trimmed_mean_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_window_trimmed_mean_core
// Drives load-cell samples and trim writes into the trimmed-mean core with
// random gaps and back-pressure, including one long output hold-off, while
// the checker predicts and compares every mean beat.
// ----------------------------------------------------------------------------

module tb_sliding_window_trimmed_mean_core;
  import swtm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_ITEMS = 48;
  localparam int DIRECTED_ITEMS = 20;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [SAMPLE_W-1:0]           in_tdata;
  logic [0:0]                    in_tuser;
  logic                          out_tvalid;
  logic                          out_tready;
  logic [MEAN_W+2*CNT_W-1:0]     out_tdata;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [TRIM_W-1:0]             cfg_data;
  int                            mismatches;
  int                            means_pending;
  int                            cycle_count = 0;
  bit                            idle_on = 1'b1;
  bit                            hold_req = 1'b0;
  int                            load_base = 0;

  // trim settings per random phase, extremes early
  int trim_plan [8] = '{0, 7, 1, 5, 3, 6, 2, 4};

  // directed samples: extremes, signs, duplicates, wrap and two restarts
  int dir_vals [DIRECTED_ITEMS] = '{
    8388607, -8388608, 8388607, 0, -1, 1, 5, 5, 5, -8388608,
    8388607, 8388607, -5, 5, 100, 5, -8388608, -1, 42, -7
  };
  bit dir_rst [DIRECTED_ITEMS] = '{
    1, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0, 1, 0
  };

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sliding_window_trimmed_mean_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  trimmed_mean_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .means_pending (means_pending)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // sample mix: full range, extremes, small values with many ties, and a
  // drifting load level with noise
  function automatic logic [SAMPLE_W-1:0] draw_sample();
    logic [SAMPLE_W-1:0] s;
    if ($urandom_range(0, 15) == 0) load_base = int'($urandom()) >>> 9;
    case ($urandom_range(0, 3))
      0: s = SAMPLE_W'($urandom());
      1: begin
        case ($urandom_range(0, 3))
          0: s = 24'h7FFFFF;
          1: s = 24'h800000;
          2: s = 24'h000000;
          default: s = 24'hFFFFFF;
        endcase
      end
      2: s = SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
      default: s = SAMPLE_W'(load_base + int'($urandom_range(0, 64)) - 32);
    endcase
    return s;
  endfunction

  // one sample beat; valid stays high on return
  task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic restart);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata = smp;
    in_tuser = restart;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // trim write, only once every mean beat has come back
  task automatic write_trim(input int t);
    while (means_pending != 0) @(negedge clk);
    cfg_data = TRIM_W'(t);
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // mean receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    out_tready = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = idle_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    int ph;
    int k;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed part at the reset trim
    for (k = 0; k < DIRECTED_ITEMS; k++)
      push_sample(SAMPLE_W'(dir_vals[k]), dir_rst[k]);
    in_tvalid = 1'b0;

    // random phases, one trim setting each
    for (ph = 0; ph < 8; ph++) begin
      write_trim(trim_plan[ph]);
      idle_on = (ph != 2 && ph != 5);
      if (ph == 1) hold_req = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++)
        push_sample(draw_sample(), $urandom_range(0, 19) == 0);
      in_tvalid = 1'b0;
    end

    while (means_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && means_pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

[filelist.f]
rtl/swtm_pkg.sv
rtl/swtm_div.sv
rtl/sliding_window_trimmed_mean_core.sv
rtl/swtm_checker.sv
sim/trimmed_mean_checker.sv
sim/tb_sliding_window_trimmed_mean_core.sv
